### rtl/display_command_frame_parser_top_assert.svh
// Assertion macros used by the display command frame parser core module
`ifndef DISPLAY_COMMAND_FRAME_PARSER_TOP_ASSERT_SVH
`define DISPLAY_COMMAND_FRAME_PARSER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define DCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define DCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dcfp_pkg.sv
// Shared constants and types for the display command frame parser
package dcfp_pkg;

    // Frame geometry
    localparam int FRAME_MAX = 30;
    localparam int POS_W     = 6;
    localparam int WATCH_N   = 3;
    localparam logic [POS_W-1:0] WATCH_POS [WATCH_N] = '{6'd4, 6'd5, 6'd10};

    // Marker bytes
    localparam logic [7:0] START_BYTE = 8'hEE;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] MODE_BYTE  = 8'h0F;
    localparam logic [7:0] UP_BYTE    = 8'hC6;
    localparam logic [7:0] DOWN_BYTE  = 8'hC5;

    // Reset values
    localparam logic [7:0] STEP_RESET  = 8'd10;
    localparam logic [9:0] UPPER_RESET = 10'd400;
    localparam logic [9:0] LOWER_RESET = 10'd10;
    localparam logic [9:0] SPEED_RESET = 10'd100;

    typedef enum logic [1:0] {
        REG_SPEED_STEP  = 2'd0,
        REG_SPEED_UPPER = 2'd1,
        REG_SPEED_LOWER = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RAISE = 2'd1,
        CMD_LOWER = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [7:0] step;
        logic [9:0] upper;
        logic [9:0] lower;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } beat_t;

endpackage

### rtl/display_command_frame_parser_top.sv
// A byte is captured in the input register; the parser state and the result register
// then register its update together. Throughput: one byte per cycle; the two registers
// pipeline with the parser update between them, stalling only on out_ready.
// Reset: rst_n clears position, kept bytes and valids; speed resets to 100 and
// the step, upper and lower registers to 10, 400 and 10.
module display_command_frame_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_done,
    output logic [5:0]  end_position,
    output logic [1:0]  command_applied,
    output logic [9:0]  speed_setting,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    dcfp_pkg::beat_t beat;
    dcfp_pkg::cfg_t  cfg;
    logic            take;

    dcfp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcfp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .beat     (beat)
    );

    dcfp_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .beat            (beat),
        .cfg             (cfg),
        .take            (take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_done      (frame_done),
        .end_position    (end_position),
        .command_applied (command_applied),
        .speed_setting   (speed_setting)
    );

endmodule

### rtl/dcfp_cfg_regs.sv
// Speed step and limit registers of the frame parser
module dcfp_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data,
    output dcfp_pkg::cfg_t      cfg
);

    dcfp_pkg::cfg_t cfg_reg;
    dcfp_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (dcfp_pkg::reg_index_t'(cfg_index))
                dcfp_pkg::REG_SPEED_STEP:  cfg_next.step  = cfg_data[7:0];
                dcfp_pkg::REG_SPEED_UPPER: cfg_next.upper = cfg_data;
                dcfp_pkg::REG_SPEED_LOWER: cfg_next.lower = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step  <= dcfp_pkg::STEP_RESET;
            cfg_reg.upper <= dcfp_pkg::UPPER_RESET;
            cfg_reg.lower <= dcfp_pkg::LOWER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/dcfp_in_stage.sv
// Input register that captures one received byte per beat
module dcfp_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                take,
    output dcfp_pkg::beat_t     beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Accept when empty or when the held beat moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until it advances
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

### rtl/dcfp_core.sv
// Frame tracking, kept copy, speed update and result register
module dcfp_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  dcfp_pkg::beat_t     beat,
    input  dcfp_pkg::cfg_t      cfg,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                frame_done,
    output logic [5:0]          end_position,
    output logic [1:0]          command_applied,
    output logic [9:0]          speed_setting
);

    localparam int PW = dcfp_pkg::POS_W;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [7:0]    prev_reg;
    logic [7:0]    prev_next;
    logic [7:0]    cur_reg  [dcfp_pkg::WATCH_N];
    logic [7:0]    cur_next [dcfp_pkg::WATCH_N];
    logic [7:0]    kept_reg [dcfp_pkg::WATCH_N];
    logic [7:0]    kept_next[dcfp_pkg::WATCH_N];
    logic [9:0]    speed_reg;
    logic [9:0]    speed_next;

    logic          active;
    logic          done;
    logic [PW:0]   pos_inc;
    logic [10:0]   raise_sum;
    logic [9:0]    raise_val;
    logic [9:0]    lower_diff;
    logic [9:0]    lower_val;
    dcfp_pkg::cmd_t cmd;

    logic          out_valid_reg;
    logic          done_reg;
    logic [PW-1:0] endp_reg;
    dcfp_pkg::cmd_t cmd_reg;
    logic [9:0]    result_speed_reg;

    // Advance when the result register is free or being drained
    assign take   = !out_valid_reg || out_ready;
    assign active = beat.valid && take
                    && (pos_reg != '0 || beat.data == dcfp_pkg::START_BYTE);
    assign done   = active && pos_reg >= PW'(2)
                    && beat.data == dcfp_pkg::END_BYTE
                    && prev_reg == dcfp_pkg::END_BYTE;
    assign pos_inc = {1'b0, pos_reg} + (PW+1)'(1);

    // Capture watched bytes and copy them on frame end
    always_comb
    begin
        for (int k = 0; k < dcfp_pkg::WATCH_N; k++)
        begin
            cur_next[k]  = (active && pos_reg == dcfp_pkg::WATCH_POS[k])
                           ? beat.data : cur_reg[k];
            kept_next[k] = (done && dcfp_pkg::WATCH_POS[k] < pos_reg)
                           ? cur_reg[k] : kept_reg[k];
        end
    end

    // Step the byte position; restart on frame end or overlong frame
    always_comb
    begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        if (active)
        begin
            prev_next = beat.data;
            if (done || pos_inc >= (PW+1)'(dcfp_pkg::FRAME_MAX))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[PW-1:0];
            end
        end
    end

    // Saturating speed candidates
    assign raise_sum  = {1'b0, speed_reg} + {3'b000, cfg.step};
    assign raise_val  = (raise_sum >= {1'b0, cfg.upper}) ? cfg.upper : raise_sum[9:0];
    assign lower_diff = (speed_reg > {2'b00, cfg.step})
                        ? speed_reg - {2'b00, cfg.step} : 10'd0;
    assign lower_val  = (lower_diff <= cfg.lower) ? cfg.lower : lower_diff;

    // Decode the speed command from the kept copy
    always_comb
    begin
        cmd        = dcfp_pkg::CMD_NONE;
        speed_next = speed_reg;
        if (done && kept_next[2] == dcfp_pkg::MODE_BYTE)
        begin
            if (kept_next[0] == dcfp_pkg::UP_BYTE && kept_next[1] == dcfp_pkg::UP_BYTE)
            begin
                cmd        = dcfp_pkg::CMD_RAISE;
                speed_next = raise_val;
            end
            else if (kept_next[0] == dcfp_pkg::DOWN_BYTE
                     && kept_next[1] == dcfp_pkg::DOWN_BYTE)
            begin
                cmd        = dcfp_pkg::CMD_LOWER;
                speed_next = lower_val;
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            prev_reg  <= '0;
            speed_reg <= dcfp_pkg::SPEED_RESET;
            for (int k = 0; k < dcfp_pkg::WATCH_N; k++)
            begin
                cur_reg[k]  <= '0;
                kept_reg[k] <= '0;
            end
        end
        else
        begin
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            speed_reg <= speed_next;
            for (int k = 0; k < dcfp_pkg::WATCH_N; k++)
            begin
                cur_reg[k]  <= cur_next[k];
                kept_reg[k] <= kept_next[k];
            end
        end
    end

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= beat.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take && beat.valid)
        begin
            done_reg         <= done;
            endp_reg         <= done ? pos_reg : '0;
            cmd_reg          <= cmd;
            result_speed_reg <= speed_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_done      = done_reg;
    assign end_position    = endp_reg;
    assign command_applied = cmd_reg;
    assign speed_setting   = result_speed_reg;

`include "display_command_frame_parser_top_assert.svh"

    `DCFP_ASSERT_NOW(a_cmd_needs_done, out_valid_reg && cmd_reg != dcfp_pkg::CMD_NONE, done_reg, "command reported without frame end")
    `DCFP_ASSERT_NOW(a_pos_in_range, 1'b1, (PW+1)'(pos_reg) < (PW+1)'(dcfp_pkg::FRAME_MAX), "byte position reached frame limit")
    `DCFP_ASSERT_NOW(a_end_pos_min, out_valid_reg && done_reg, endp_reg >= PW'(2), "frame end before position two")
    `DCFP_ASSERT_NEXT(a_drop_bad_start, beat.valid && take && pos_reg == '0 && beat.data != dcfp_pkg::START_BYTE, pos_reg == '0, "bad start byte advanced position")

endmodule
